// ----- design/fbpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framebuffer pixel access: shared package
// Store geometry, field widths, register indexes and small helper
// functions that are used by the pixel access block and its channels.
// ----------------------------------------------------------------------------
package fbpa_pkg;

	// Image store geometry. The store is split into byte banks so that one
	// pixel of up to four bytes touches every bank at most once.
	localparam int STORE_BYTES = 65536;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int NUM_BANKS   = 4;
	localparam int BANK_W      = $clog2(NUM_BANKS);
	localparam int ROW_W       = ADDR_W - BANK_W;
	localparam int BANK_ROWS   = STORE_BYTES / NUM_BANKS;

	// Largest width or height that is honored; larger settings are clamped.
	localparam int MAX_DIMENSION = 4096;

	// Field widths.
	localparam int DIM_W      = 13;
	localparam int STRIDE_W   = 15;
	localparam int BPP_W      = 3;
	localparam int POS_W      = 16;
	localparam int MAG_W      = POS_W - 1;
	localparam int WVAL_W     = 32;
	localparam int RVAL_W     = 24;
	localparam int CMP_W      = 16;
	localparam int LINE_W     = MAG_W + STRIDE_W;
	localparam int OFFS_W     = MAG_W + BPP_W;
	localparam int SUM_W      = 32;
	localparam int RES_BYTES  = RVAL_W / 8;
	localparam int BIT_SEL_W  = 3;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_BIT_MODE    = 3'd4;

	// Request types.
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// Reset value of the pixel size and the largest legal pixel size.
	localparam logic [BPP_W-1:0] BPP_RESET = 3'd1;
	localparam logic [BPP_W-1:0] BPP_MAX   = 3'd4;

	// Top byte stored for four-byte pixels, and the first bit of a packed byte.
	localparam logic [7:0] PAD_BYTE = 8'hFF;
	localparam logic [7:0] MSB_MASK = 8'h80;

	// Width or height as seen by the bounds check.
	function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [CMP_W-1:0] dw;
		dw = CMP_W'(d);
		return (dw > CMP_W'(MAX_DIMENSION)) ? CMP_W'(MAX_DIMENSION) : dw;
	endfunction

endpackage

// ----- design/fbpa_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framebuffer pixel access: channel interfaces
// Valid/ready channels for pixel requests, read results and register writes.
// ----------------------------------------------------------------------------

// Pixel request channel.
interface fbpa_req_if import fbpa_pkg::*;;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [POS_W-1:0]  pos_x;
	logic [POS_W-1:0]  pos_y;
	logic [WVAL_W-1:0] write_value;

	modport source (output valid, output req_type, output pos_x, output pos_y,
		output write_value, input ready);
	modport sink (input valid, input req_type, input pos_x, input pos_y,
		input write_value, output ready);
endinterface

// Read result channel.
interface fbpa_rsp_if import fbpa_pkg::*;;
	logic              valid;
	logic              ready;
	logic [RVAL_W-1:0] read_value;

	modport source (output valid, output read_value, input ready);
	modport sink (input valid, input read_value, output ready);
endinterface

// Register write channel.
interface fbpa_cfg_if import fbpa_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/framebuffer_pixel_access.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framebuffer pixel access
// Reads or writes one pixel of a byte-addressed image store, in packed
// one-bit mode or with pixels of one to four little-endian bytes.
// ----------------------------------------------------------------------------
// The block holds one request at a time and takes a new request only once
// the held one is finishing, as long as read results are taken. A request is
// registered, then its address is formed and the four byte banks of the store
// are read (or written, for byte pixels); in the second stage the read data is
// turned into a result or, for a one-bit write, the modified byte is written
// back. That read-modify-write through the bank read and write ports is why
// requests do not overlap. A read result passes through the request register,
// the second-stage registers and the output register before it is offered, and
// it waits in the output register while the next request proceeds.
// Writes give no result. Out-of-bounds requests, pixels that run past the
// store and illegal pixel sizes read as zero and write nothing. Store bytes
// read before they are ever written return unspecified data.
// ----------------------------------------------------------------------------
module framebuffer_pixel_access import fbpa_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	fbpa_cfg_if.sink    cfg,
	fbpa_req_if.sink    req,
	fbpa_rsp_if.source  rsp
);

	// Configuration registers.
	logic [DIM_W-1:0]    width_q;
	logic [DIM_W-1:0]    height_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [BPP_W-1:0]    bpp_q;
	logic                one_bit_q;

	// First stage: registered request.
	logic              valid_s1;
	logic              type_s1;
	logic [POS_W-1:0]  pos_x_s1;
	logic [POS_W-1:0]  pos_y_s1;
	logic [RVAL_W-1:0] wval_s1;

	// Second stage: registered address facts and bank read data.
	logic                 valid_s2;
	logic                 type_s2;
	logic                 ok_s2;
	logic                 one_bit_s2;
	logic [BPP_W-1:0]     cnt_s2;
	logic [BANK_W-1:0]    bank_s2;
	logic [ROW_W-1:0]     row_s2;
	logic [BIT_SEL_W-1:0] bit_sel_s2;
	logic                 wbit_s2;
	logic [7:0]           rdata_s2 [NUM_BANKS];

	// Output register.
	logic              out_valid_q;
	logic [RVAL_W-1:0] read_value_q;

	// First-stage address logic.
	logic              in_bounds;
	logic              size_ok;
	logic              in_store;
	logic              ok_s1c;
	logic [LINE_W-1:0] line_addr;
	logic [OFFS_W-1:0] offset;
	logic [SUM_W-1:0]  pix_addr;
	logic [SUM_W-1:0]  pix_end;
	logic [BPP_W-1:0]  cnt_s1c;
	logic [ADDR_W-1:0] base_addr;
	logic              byte_write;

	// Bank ports.
	logic              bank_we    [NUM_BANKS];
	logic [ROW_W-1:0]  bank_waddr [NUM_BANKS];
	logic [7:0]        bank_wdata [NUM_BANKS];
	logic [ROW_W-1:0]  bank_raddr [NUM_BANKS];
	logic              lane_we    [NUM_BANKS];
	logic [7:0]        lane_data  [NUM_BANKS];

	// Second-stage logic.
	logic [7:0]        packed_byte;
	logic [7:0]        bit_mask;
	logic [7:0]        wb_byte;
	logic              wb_en;
	logic [RVAL_W-1:0] pixel;
	logic [RVAL_W-1:0] result;
	logic              out_load;
	logic              s2_done;
	logic              accept;

	// Handshakes. A new request enters once the held one is finishing.
	assign cfg.ready  = 1'b1;
	assign s2_done    = valid_s2 && (type_s2 == REQ_WRITE || !out_valid_q || rsp.ready);
	assign out_load   = valid_s2 && type_s2 == REQ_READ && (!out_valid_q || rsp.ready);
	assign req.ready  = !valid_s1 && (!valid_s2 || s2_done);
	assign accept     = req.valid && req.ready;
	assign rsp.valid  = out_valid_q;
	assign rsp.read_value = read_value_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= '0;
			height_q  <= '0;
			stride_q  <= '0;
			bpp_q     <= BPP_RESET;
			one_bit_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_IMAGE_WIDTH:     width_q   <= cfg.data[DIM_W-1:0];
				REG_IMAGE_HEIGHT:    height_q  <= cfg.data[DIM_W-1:0];
				REG_LINE_STRIDE:     stride_q  <= cfg.data[STRIDE_W-1:0];
				REG_BYTES_PER_PIXEL: bpp_q     <= cfg.data[BPP_W-1:0];
				REG_ONE_BIT_MODE:    one_bit_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Stage valid flags and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (s2_done) begin
				valid_s2 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request register.
	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1  <= req.req_type;
			pos_x_s1 <= req.pos_x;
			pos_y_s1 <= req.pos_y;
			wval_s1  <= req.write_value[RVAL_W-1:0];
		end
	end

	// Bounds, pixel size and store range of the held request.
	always_comb begin
		in_bounds = !pos_x_s1[POS_W-1] && !pos_y_s1[POS_W-1]
			&& CMP_W'(pos_x_s1[MAG_W-1:0]) < clamp_dim(width_q)
			&& CMP_W'(pos_y_s1[MAG_W-1:0]) < clamp_dim(height_q);
		size_ok   = one_bit_q || (bpp_q != '0 && bpp_q <= BPP_MAX);
		line_addr = LINE_W'(pos_y_s1[MAG_W-1:0]) * LINE_W'(stride_q);
		if (one_bit_q) begin
			offset  = OFFS_W'(pos_x_s1[MAG_W-1:BIT_SEL_W]);
			cnt_s1c = BPP_W'(1);
		end else begin
			offset  = OFFS_W'(pos_x_s1[MAG_W-1:0]) * OFFS_W'(bpp_q);
			cnt_s1c = bpp_q;
		end
		pix_addr   = SUM_W'(line_addr) + SUM_W'(offset);
		pix_end    = pix_addr + SUM_W'(cnt_s1c);
		in_store   = pix_end <= SUM_W'(STORE_BYTES);
		ok_s1c     = in_bounds && size_ok && in_store;
		base_addr  = pix_addr[ADDR_W-1:0];
		byte_write = valid_s1 && type_s1 == REQ_WRITE && ok_s1c && !one_bit_q;
	end

	// Byte lane of each bank and its row, data and write enable.
	always_comb begin
		logic [BANK_W-1:0] lane;
		logic [ADDR_W-1:0] lane_addr;
		for (int k = 0; k < NUM_BANKS; k++) begin
			lane          = BANK_W'(k) - base_addr[BANK_W-1:0];
			lane_addr     = base_addr + ADDR_W'(lane);
			bank_raddr[k] = lane_addr[ADDR_W-1:BANK_W];
			lane_we[k]    = byte_write && BPP_W'(lane) < cnt_s1c;
			if (32'(lane) >= RES_BYTES) begin
				lane_data[k] = PAD_BYTE;
			end else begin
				lane_data[k] = wval_s1[8*lane +: 8];
			end
		end
	end

	// Bank write ports: byte-pixel writes from the first stage, one-bit
	// write-back from the second. The two never overlap in time.
	always_comb begin
		for (int k = 0; k < NUM_BANKS; k++) begin
			if (wb_en && bank_s2 == BANK_W'(k)) begin
				bank_we[k]    = 1'b1;
				bank_waddr[k] = row_s2;
				bank_wdata[k] = wb_byte;
			end else begin
				bank_we[k]    = lane_we[k];
				bank_waddr[k] = bank_raddr[k];
				bank_wdata[k] = lane_data[k];
			end
		end
	end

	// Byte banks of the image store, with registered read data.
	for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
		logic [7:0] mem_q [BANK_ROWS];

		always_ff @(posedge clk) begin
			if (bank_we[k]) begin
				mem_q[bank_waddr[k]] <= bank_wdata[k];
			end
			rdata_s2[k] <= mem_q[bank_raddr[k]];
		end
	end

	// Second-stage request facts.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			type_s2    <= type_s1;
			ok_s2      <= ok_s1c;
			one_bit_s2 <= one_bit_q;
			cnt_s2     <= cnt_s1c;
			bank_s2    <= base_addr[BANK_W-1:0];
			row_s2     <= base_addr[ADDR_W-1:BANK_W];
			bit_sel_s2 <= pos_x_s1[BIT_SEL_W-1:0];
			wbit_s2    <= wval_s1[0];
		end
	end

	// One-bit pixel: pick the bit, most significant first, and form the
	// write-back byte.
	assign packed_byte = rdata_s2[bank_s2];
	assign bit_mask    = MSB_MASK >> bit_sel_s2;
	assign wb_byte     = wbit_s2 ? (packed_byte | bit_mask) : (packed_byte & ~bit_mask);
	assign wb_en       = valid_s2 && type_s2 == REQ_WRITE && ok_s2 && one_bit_s2;

	// Byte pixel: gather up to three little-endian bytes.
	always_comb begin
		logic [BANK_W-1:0] bank;
		pixel = '0;
		for (int i = 0; i < RES_BYTES; i++) begin
			bank = bank_s2 + BANK_W'(i);
			if (BPP_W'(i) < cnt_s2) begin
				pixel[8*i +: 8] = rdata_s2[bank];
			end
		end
	end

	always_comb begin
		if (!ok_s2) begin
			result = '0;
		end else if (one_bit_s2) begin
			result = RVAL_W'(|(packed_byte & bit_mask));
		end else begin
			result = pixel;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			read_value_q <= result;
		end
	end

endmodule

// ----- design/fbpa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framebuffer pixel access: port checker
// Watches the request and result channels of the pixel access block.
// ----------------------------------------------------------------------------
module fbpa_checker import fbpa_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              req_type,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [RVAL_W-1:0] rsp_read_value
);

	logic req_fire;

	assign req_fire = req_valid && req_ready;

	// A result that is not taken stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn before it was taken");

	// A result that is not taken keeps its value.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_read_value))
		else $error("result changed while stalled");

	// Only one request is held: the cycle after a request is taken, no other is.
	a_one_held: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req_ready)
		else $error("request taken while another is held");

	// A fresh result follows a taken request through the request, second-stage and output registers.
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_fire, 3))
		else $error("result without a matching request");

	// A write request gives no result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req_type == REQ_WRITE |-> ##3 !$rose(rsp_valid))
		else $error("write request produced a result");

endmodule

bind framebuffer_pixel_access fbpa_checker u_fbpa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_type       (req.req_type),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_value (rsp.read_value)
);
